### sv/btlv_pkg.sv
package btlv_pkg;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_TAG_MORE  = 3'd1;
  localparam logic [2:0] PH_LEN_FIRST = 3'd2;
  localparam logic [2:0] PH_LEN_MORE  = 3'd3;
  localparam logic [2:0] PH_VALUE     = 3'd4;

  localparam logic [1:0] ROLE_FILLER = 2'd0;
  localparam logic [1:0] ROLE_TAG    = 2'd1;
  localparam logic [1:0] ROLE_LENGTH = 2'd2;
  localparam logic [1:0] ROLE_VALUE  = 2'd3;

  localparam logic [7:0] FILL_ZERO  = 8'h00;
  localparam logic [7:0] FILL_ONES  = 8'hFF;
  localparam logic [4:0] TAG_MULTI  = 5'h1F;
  localparam logic [3:0] TAG_CNT_MAX = 4'd15;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [1:0]  byte_role;
    logic        node_complete;
    logic [31:0] node_tag;
    logic [3:0]  tag_byte_count;
    logic [31:0] node_length;
    logic        value_truncated;
  } btlv_result_t;

endpackage

### sv/btlv_stream_if.sv
interface btlv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface btlv_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [1:0]  byte_role;
  logic        node_complete;
  logic [31:0] node_tag;
  logic [3:0]  tag_byte_count;
  logic [31:0] node_length;
  logic        value_truncated;

  modport source (
    output valid, output byte_out, output byte_role, output node_complete,
    output node_tag, output tag_byte_count, output node_length,
    output value_truncated, input ready
  );
  modport sink (
    input valid, input byte_out, input byte_role, input node_complete,
    input node_tag, input tag_byte_count, input node_length,
    input value_truncated, output ready
  );
endinterface

### sv/ber_tlv_stream_parser.sv
// Flat BER-TLV parser over a byte stream. One byte is taken per cycle while the
// parser has room, and each byte gives exactly one result in the next cycle,
// carrying the byte, its role (filler, tag, length, value) and, on the byte that
// closes a node, the tag, the tag byte count, the length and a truncation flag.
// Throughput is one byte per clock, set by the single parse-state update between
// the input handshake and the result register; the result register frees as it
// is read, so input is held back only while a result waits unread. A byte
// marked last returns the parser to its start state after it is handled.
module ber_tlv_stream_parser
  import btlv_pkg::*;
#(
  parameter int TAG_KEEP_BYTES = 4,
  parameter int LENGTH_WIDTH   = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  btlv_in_if.sink      in_chan,
  btlv_out_if.source   out_chan
);

  btlv_result_t step_res;
  btlv_result_t reg_res;
  logic         room;
  logic         accept;

  assign in_chan.ready = room;
  assign accept        = in_chan.valid && room;

  btlv_parse #(
    .TAG_KEEP_BYTES (TAG_KEEP_BYTES),
    .LENGTH_WIDTH   (LENGTH_WIDTH)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_chan.data_byte),
    .last_byte (in_chan.last_byte),
    .res       (step_res)
  );

  btlv_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res       (step_res),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_res   (reg_res),
    .room      (room)
  );

  assign out_chan.byte_out        = reg_res.byte_out;
  assign out_chan.byte_role       = reg_res.byte_role;
  assign out_chan.node_complete   = reg_res.node_complete;
  assign out_chan.node_tag        = reg_res.node_tag;
  assign out_chan.tag_byte_count  = reg_res.tag_byte_count;
  assign out_chan.node_length     = reg_res.node_length;
  assign out_chan.value_truncated = reg_res.value_truncated;

endmodule

### sv/btlv_parse.sv
module btlv_parse
  import btlv_pkg::*;
#(
  parameter int TAG_KEEP_BYTES = 4,
  parameter int LENGTH_WIDTH   = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  output btlv_result_t res
);

  localparam int TAG_W = (TAG_KEEP_BYTES * 8 > 32) ? 32 : TAG_KEEP_BYTES * 8;
  localparam int LW    = LENGTH_WIDTH;

  logic [2:0]       phase_r, phase_nxt;
  logic [TAG_W-1:0] tag_acc_r, tag_acc_nxt;
  logic [3:0]       tag_cnt_r, tag_cnt_nxt;
  logic [LW-1:0]    len_acc_r, len_acc_nxt;
  logic [6:0]       len_left_r, len_left_nxt;
  logic [LW-1:0]    val_left_r, val_left_nxt;
  logic [LW-1:0]    val_seen_r, val_seen_nxt;

  logic [TAG_W+7:0] tag_shift;
  logic [LW+7:0]    len_shift;
  logic [LW-1:0]    len_val;
  logic [LW-1:0]    seen_inc;
  logic [LW-1:0]    left_dec;
  logic             len_done;

  assign tag_shift = {tag_acc_r, data_byte};
  assign len_shift = {len_acc_r, data_byte};
  assign seen_inc  = val_seen_r + LW'(1);
  assign left_dec  = val_left_r - LW'(1);

  always_comb begin
    phase_nxt    = phase_r;
    tag_acc_nxt  = tag_acc_r;
    tag_cnt_nxt  = tag_cnt_r;
    len_acc_nxt  = len_acc_r;
    len_left_nxt = len_left_r;
    val_left_nxt = val_left_r;
    val_seen_nxt = val_seen_r;
    len_val      = '0;
    len_done     = 1'b0;

    res                 = '0;
    res.byte_out        = data_byte;
    res.byte_role       = ROLE_FILLER;

    unique case (phase_r)
      PH_IDLE: begin
        if (data_byte != FILL_ZERO && data_byte != FILL_ONES) begin
          res.byte_role = ROLE_TAG;
          tag_acc_nxt   = TAG_W'(data_byte);
          tag_cnt_nxt   = 4'd1;
          phase_nxt     = (data_byte[4:0] == TAG_MULTI) ? PH_TAG_MORE : PH_LEN_FIRST;
        end
      end
      PH_TAG_MORE: begin
        res.byte_role = ROLE_TAG;
        if (int'(tag_cnt_r) < TAG_KEEP_BYTES) begin
          tag_acc_nxt = tag_shift[TAG_W-1:0];
        end
        if (tag_cnt_r != TAG_CNT_MAX) begin
          tag_cnt_nxt = tag_cnt_r + 4'd1;
        end
        if (!data_byte[7]) begin
          phase_nxt = PH_LEN_FIRST;
        end
      end
      PH_LEN_FIRST: begin
        res.byte_role = ROLE_LENGTH;
        if (!data_byte[7]) begin
          len_val  = LW'(data_byte[6:0]);
          len_done = 1'b1;
        end else begin
          len_left_nxt = data_byte[6:0];
          if (data_byte[6:0] == 7'd0) begin
            len_done = 1'b1;
          end else begin
            phase_nxt = PH_LEN_MORE;
          end
        end
        len_acc_nxt = len_val;
      end
      PH_LEN_MORE: begin
        res.byte_role = ROLE_LENGTH;
        len_val       = len_shift[LW-1:0];
        len_acc_nxt   = len_val;
        len_left_nxt  = len_left_r - 7'd1;
        if (len_left_nxt == 7'd0) begin
          len_done = 1'b1;
        end
      end
      PH_VALUE: begin
        res.byte_role = ROLE_VALUE;
        val_seen_nxt  = seen_inc;
        val_left_nxt  = left_dec;
        if (left_dec == '0 || last_byte) begin
          res.node_complete   = 1'b1;
          res.node_tag        = 32'(tag_acc_r);
          res.tag_byte_count  = tag_cnt_r;
          res.node_length     = 32'(seen_inc);
          res.value_truncated = (left_dec != '0);
          phase_nxt           = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    if (len_done) begin
      if (len_val == '0 || last_byte) begin
        res.node_complete   = 1'b1;
        res.node_tag        = 32'(tag_acc_r);
        res.tag_byte_count  = tag_cnt_r;
        res.node_length     = '0;
        res.value_truncated = (len_val != '0);
        phase_nxt           = PH_IDLE;
      end else begin
        val_left_nxt = len_val;
        val_seen_nxt = '0;
        phase_nxt    = PH_VALUE;
      end
    end

    if (last_byte) begin
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (accept) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_acc_r  <= tag_acc_nxt;
      tag_cnt_r  <= tag_cnt_nxt;
      len_acc_r  <= len_acc_nxt;
      len_left_r <= len_left_nxt;
      val_left_r <= val_left_nxt;
      val_seen_r <= val_seen_nxt;
    end
  end

endmodule

### sv/btlv_out_reg.sv
module btlv_out_reg
  import btlv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  btlv_result_t res,
  input  logic         out_ready,
  output logic         out_valid,
  output btlv_result_t out_res,
  output logic         room
);

  logic         valid_r, valid_nxt;
  btlv_result_t res_r;

  assign room      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule
